FILE: src/jps_pkg.sv
package jps_pkg;

	typedef struct packed {
		logic signed [31:0] phi_old;
		logic signed [31:0] source;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] phi_new;
		logic [30:0]        peak_delta;
		logic               sweep_last;
		logic               converged;
	} result_t;

	// register word index (paddr[3:2])
	localparam logic [1:0] REG_GRID_SIZE    = 2'd0;
	localparam logic [1:0] REG_STEP_SQUARED = 2'd1;
	localparam logic [1:0] REG_TOLERANCE    = 2'd2;

	localparam logic [10:0] GRID_SIZE_RST    = 11'd512;
	localparam logic [31:0] STEP_SQUARED_RST = 32'd16320;
	localparam logic [30:0] TOLERANCE_RST    = 31'd1074;

endpackage

FILE: src/jacobi_poisson_sweep_top.sv
// Channel   Direction  Handshake                     Payload
// sample    in         sample_valid / sample_stall   jps_pkg::sample_t (phi_old, source)
// result    out        result_valid / result_stall   jps_pkg::result_t
// config    in         APB (psel, penable, pwrite)   grid_size, step_squared, tolerance
//
// One grid point per cycle while sample_stall is low; the padded (N+2)x(N+2) grid
// streams in raster order. Interior point (i,j) leaves after grid point (i+1,j+1)
// is accepted, via line buffer read, stencil sum and difference/max into the output
// register. After reset the line buffers are zeroed one entry per cycle, MAX_GRID+2
// entries (1026 at the default) with sample_stall high; config writes are taken meanwhile.
// result_stall backs up through the output register and two stages to sample_stall.
module jacobi_poisson_sweep_top #(
	parameter int MAX_GRID = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  jps_pkg::sample_t sample,
	output logic             result_valid,
	input  logic             result_stall,
	output jps_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int LineDepth = MAX_GRID + 2;
	localparam int Cw = $clog2(LineDepth);
	localparam int Nw = (Cw > 11) ? Cw : 11;
	localparam logic [Cw-1:0] LastIdx = Cw'(LineDepth - 1);
	localparam logic [Nw-1:0] MaxN = Nw'(MAX_GRID);

	// configuration registers
	logic [10:0] grid_size_q;
	logic [31:0] step_sq_q;
	logic [30:0] tol_q;
	logic        cfg_wr;

	assign cfg_wr = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= jps_pkg::GRID_SIZE_RST;
			step_sq_q   <= jps_pkg::STEP_SQUARED_RST;
			tol_q       <= jps_pkg::TOLERANCE_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				jps_pkg::REG_GRID_SIZE:    grid_size_q <= pwdata[10:0];
				jps_pkg::REG_STEP_SQUARED: step_sq_q   <= pwdata;
				jps_pkg::REG_TOLERANCE:    tol_q       <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			jps_pkg::REG_GRID_SIZE:    prdata = {21'd0, grid_size_q};
			jps_pkg::REG_STEP_SQUARED: prdata = step_sq_q;
			jps_pkg::REG_TOLERANCE:    prdata = {1'b0, tol_q};
			default:                   prdata = '0;
		endcase
	end

	// clamped grid size
	logic [Nw-1:0] gs_ext;
	logic [Nw-1:0] n_clamp;
	logic [Cw-1:0] n_p1;

	always_comb begin
		gs_ext = Nw'(grid_size_q);
		if (gs_ext == '0) begin
			n_clamp = Nw'(1);
		end else if (gs_ext > MaxN) begin
			n_clamp = MaxN;
		end else begin
			n_clamp = gs_ext;
		end
		n_p1 = n_clamp[Cw-1:0] + Cw'(1);
	end

	// control state
	logic          clr_q;
	logic [Cw-1:0] clr_idx_q;
	logic [Cw-1:0] col_q;
	logic [Cw-1:0] row_q;
	logic          s1_v_q;
	logic          s2_v_q;
	logic          res_v_q;
	logic [30:0]   rm_q;
	logic          pend_v_q;
	logic signed [31:0] bl_phi_q;
	logic signed [31:0] bl_src_q;
	logic signed [31:0] win_q;

	logic accept;
	logic s1_adv;
	logic s2_adv;
	logic res_take;

	// position decode for the item at the input
	logic has_c;
	logic wrap;
	logic sweep_end;
	logic emit;
	logic last;

	always_comb begin
		has_c     = col_q != '0;
		wrap      = col_q >= n_p1;
		sweep_end = wrap && (row_q >= n_p1);
		emit      = (row_q >= Cw'(2)) && (col_q >= Cw'(2)) && (row_q <= n_p1)
			&& (col_q <= n_p1);
		last      = (row_q == n_p1) && (col_q == n_p1);
	end

	// s1 stage
	logic signed [31:0] phi_in_s1;
	logic signed [31:0] src_in_s1;
	logic [Cw-1:0]      col_s1;
	logic signed [31:0] up_s1;
	logic signed [31:0] mid_s1;
	logic signed [31:0] bl_s1;
	logic signed [31:0] bl_src_s1;
	logic signed [31:0] win_s1;
	logic signed [31:0] t_s1;
	logic               has_c_s1;
	logic               wrap_s1;
	logic               end_s1;
	logic               emit_s1;
	logic               last_s1;

	// line buffer read data, aligned with s1 (column of the item in s1)
	logic signed [31:0] rd_up_s1;
	logic signed [31:0] rd_ctr_s1;
	logic signed [31:0] rd_src_s1;

	// s2 stage
	logic signed [31:0] v_s2;
	logic signed [31:0] mid_s2;
	logic               emit_s2;
	logic               last_s2;
	logic               end_s2;

	jps_pkg::result_t res_q;

	// deferred write of the last column of a row
	logic [Cw-1:0]      pend_idx_q;
	logic signed [31:0] pend_up_q;
	logic signed [31:0] pend_ctr_q;
	logic signed [31:0] pend_src_q;

	assign res_take     = res_v_q & ~result_stall;
	assign s2_adv       = s2_v_q & (~emit_s2 | ~res_v_q | res_take);
	assign s1_adv       = s1_v_q & (~s2_v_q | s2_adv);
	assign sample_stall = clr_q | (s1_v_q & ~s1_adv);
	assign accept       = sample_valid & ~sample_stall;

	assign result_valid = res_v_q;
	assign result       = res_q;

	// h2*f for the column left of the incoming point
	logic signed [64:0] prod;
	logic signed [31:0] t_next;

	assign prod   = $signed({1'b0, step_sq_q}) * rd_src_s1;
	assign t_next = prod[63:32];

	// line buffers
	logic signed [31:0] up_mem  [LineDepth];
	logic signed [31:0] ctr_mem [LineDepth];
	logic signed [31:0] src_mem [LineDepth];

	logic               mem_we;
	logic [Cw-1:0]      mem_wa;
	logic signed [31:0] up_wd;
	logic signed [31:0] ctr_wd;
	logic signed [31:0] src_wd;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = col_s1 - Cw'(1);
		up_wd  = mid_s1;
		ctr_wd = bl_s1;
		src_wd = bl_src_s1;
		if (clr_q) begin
			mem_we = 1'b1;
			mem_wa = clr_idx_q;
			up_wd  = '0;
			ctr_wd = '0;
			src_wd = '0;
		end else if (pend_v_q) begin
			mem_we = 1'b1;
			mem_wa = pend_idx_q;
			up_wd  = pend_up_q;
			ctr_wd = pend_ctr_q;
			src_wd = pend_src_q;
		end else if (s1_adv && has_c_s1) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			up_mem[mem_wa]  <= up_wd;
			ctr_mem[mem_wa] <= ctr_wd;
			src_mem[mem_wa] <= src_wd;
		end
		if (accept) begin
			rd_up_s1  <= up_mem[col_q];
			rd_ctr_s1 <= ctr_mem[col_q];
			rd_src_s1 <= src_mem[col_q];
		end
	end

	// stencil sum, round to nearest, saturate
	logic signed [34:0] acc;
	logic signed [32:0] v_wide;
	logic signed [31:0] v_sat;

	always_comb begin
		acc = 35'(up_s1) + 35'(bl_s1) + 35'(win_s1) + 35'(rd_ctr_s1) - 35'(t_s1)
			+ 35'sd2;
		v_wide = acc[34:2];
		if (v_wide[32] != v_wide[31]) begin
			v_sat = v_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			v_sat = v_wide[31:0];
		end
	end

	// change magnitude and running max
	logic signed [32:0] diff;
	logic [31:0]        mag;
	logic [30:0]        dm;
	logic [30:0]        nmax;
	logic               conv;

	always_comb begin
		diff = 33'(v_s2) - 33'(mid_s2);
		mag  = diff[32] ? 32'(-diff) : diff[31:0];
		dm   = mag[31] ? 31'h7fff_ffff : mag[30:0];
		nmax = (dm > rm_q) ? dm : rm_q;
		conv = last_s2 && (nmax < tol_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
			s1_v_q    <= 1'b0;
			s2_v_q    <= 1'b0;
			res_v_q   <= 1'b0;
			rm_q      <= '0;
			pend_v_q  <= 1'b0;
			bl_phi_q  <= '0;
			bl_src_q  <= '0;
			win_q     <= '0;
		end else begin
			if (clr_q) begin
				if (clr_idx_q == LastIdx) begin
					clr_q <= 1'b0;
				end else begin
					clr_idx_q <= clr_idx_q + Cw'(1);
				end
			end

			if (accept) begin
				bl_phi_q <= sample.phi_old;
				bl_src_q <= sample.source;
				if (has_c) begin
					win_q <= rd_ctr_s1;
				end
				if (wrap) begin
					col_q <= '0;
					row_q <= (row_q >= n_p1) ? '0 : row_q + Cw'(1);
				end else begin
					col_q <= col_q + Cw'(1);
				end
			end

			if (accept) begin
				s1_v_q <= 1'b1;
			end else if (s1_adv) begin
				s1_v_q <= 1'b0;
			end

			if (s1_adv) begin
				s2_v_q <= 1'b1;
			end else if (s2_adv) begin
				s2_v_q <= 1'b0;
			end

			if (s2_adv && emit_s2) begin
				res_v_q <= 1'b1;
			end else if (res_take) begin
				res_v_q <= 1'b0;
			end

			if (s2_adv) begin
				if (end_s2) begin
					rm_q <= '0;
				end else if (emit_s2) begin
					rm_q <= nmax;
				end
			end

			pend_v_q <= s1_adv && wrap_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			phi_in_s1 <= sample.phi_old;
			src_in_s1 <= sample.source;
			col_s1    <= col_q;
			up_s1     <= rd_up_s1;
			mid_s1    <= rd_ctr_s1;
			t_s1      <= t_next;
			bl_s1     <= bl_phi_q;
			bl_src_s1 <= bl_src_q;
			win_s1    <= win_q;
			has_c_s1  <= has_c;
			wrap_s1   <= wrap;
			end_s1    <= sweep_end;
			emit_s1   <= emit;
			last_s1   <= last;
		end
		if (s1_adv) begin
			v_s2    <= v_sat;
			mid_s2  <= mid_s1;
			emit_s2 <= emit_s1;
			last_s2 <= last_s1;
			end_s2  <= end_s1;
		end
		if (s1_adv && wrap_s1) begin
			pend_idx_q <= col_s1;
			pend_up_q  <= rd_ctr_s1;
			pend_ctr_q <= phi_in_s1;
			pend_src_q <= src_in_s1;
		end
		if (s2_adv && emit_s2) begin
			res_q.phi_new    <= v_s2;
			res_q.peak_delta <= nmax;
			res_q.sweep_last <= last_s2;
			res_q.converged  <= conv;
		end
	end

	a_wr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> !(s1_adv && has_c_s1))
		else $error("deferred line write collides with stencil write");

	a_clr_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> (!s1_v_q && !s2_v_q && !pend_v_q))
		else $error("pipeline busy during line buffer clear");

	a_conv_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.converged) |-> result.sweep_last)
		else $error("converged flagged off the last point");

	a_max_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_adv && end_s2) |=> (rm_q == '0))
		else $error("running max not cleared at end of sweep");

endmodule

FILE: tb/jacobi_poisson_sweep_top_tb.sv
module jacobi_poisson_sweep_top_tb;

	localparam int MAX_GRID = 1024;
	localparam int LINE_DEPTH = MAX_GRID + 2;
	localparam int RANDOM_ITEMS = 700;
	localparam int LONG_HOLD = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	jps_pkg::sample_t sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	jps_pkg::result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	jacobi_poisson_sweep_top #(.MAX_GRID(MAX_GRID)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register copies
	logic [10:0] cfg_grid = jps_pkg::GRID_SIZE_RST;
	logic [31:0] cfg_h2 = jps_pkg::STEP_SQUARED_RST;
	logic [30:0] cfg_tol = jps_pkg::TOLERANCE_RST;

	// stencil window state
	logic signed [31:0] upper_row [LINE_DEPTH] = '{default: '0};
	logic signed [31:0] center_row [LINE_DEPTH] = '{default: '0};
	logic signed [31:0] center_src [LINE_DEPTH] = '{default: '0};
	int unsigned row_pos = 0;
	int unsigned col_pos = 0;
	longint below_left = 0;
	longint window_left = 0;
	longint below_left_src = 0;
	logic [30:0] sweep_max = '0;

	jps_pkg::sample_t pending_samples[$];
	jps_pkg::result_t expected_results[$];
	int unsigned items_pushed = 0;
	int unsigned items_accepted = 0;
	int mismatches = 0;
	jps_pkg::result_t want;

	bit sample_taken = 1'b0;
	int send_gap = 0;
	int hold_left = 0;
	bit calm = 1'b0;
	bit long_hold_go = 1'b0;
	bit long_hold_done = 1'b0;

	task automatic stencil_update(input jps_pkg::sample_t s);
		int unsigned n;
		int unsigned r;
		int unsigned c;
		longint up_v;
		longint right_v;
		longint f_v;
		longint mid_v;
		longint t_v;
		longint acc;
		longint v;
		longint d;
		bit last;
		jps_pkg::result_t res;
		n = cfg_grid;
		if (n < 1) n = 1;
		if (n > MAX_GRID) n = MAX_GRID;
		r = row_pos;
		c = col_pos;
		mid_v = 0;
		if (c >= 1) begin
			up_v = upper_row[c - 1];
			right_v = center_row[c];
			f_v = center_src[c - 1];
			mid_v = center_row[c - 1];
			if (r >= 2 && c >= 2 && r <= n + 1 && c <= n + 1) begin
				t_v = (longint'(cfg_h2) * f_v) >>> 32;
				acc = up_v + below_left + window_left + right_v - t_v;
				v = (acc + 2) >>> 2;
				if (v > 64'sd2147483647) v = 64'sd2147483647;
				if (v < -64'sd2147483648) v = -64'sd2147483648;
				d = v - mid_v;
				if (d < 0) d = -d;
				if (d > 64'sd2147483647) d = 64'sd2147483647;
				if (d > longint'(sweep_max)) sweep_max = d[30:0];
				last = (r == n + 1) && (c == n + 1);
				res.phi_new = v[31:0];
				res.peak_delta = sweep_max;
				res.sweep_last = last;
				res.converged = last && (sweep_max < cfg_tol);
				expected_results.push_back(res);
			end
			upper_row[c - 1] = mid_v[31:0];
			center_row[c - 1] = below_left[31:0];
			center_src[c - 1] = below_left_src[31:0];
			window_left = mid_v;
		end
		// right edge column: shift it straight into the line buffers
		if (c >= n + 1) begin
			upper_row[c] = center_row[c];
			center_row[c] = s.phi_old;
			center_src[c] = s.source;
		end
		below_left = s.phi_old;
		below_left_src = s.source;
		if (c >= n + 1) begin
			col_pos = 0;
			if (r >= n + 1) begin
				row_pos = 0;
				sweep_max = '0;
			end else begin
				row_pos = r + 1;
			end
		end else begin
			col_pos = c + 1;
		end
	endtask

	task automatic check_field(input string field, input logic signed [63:0] want_v,
			input logic signed [63:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want_v, got_v);
			mismatches++;
		end
	endtask

	// monitor and predictor
	always @(posedge clk) begin
		if (!arst_n) begin
			sample_taken <= 1'b0;
		end else begin
			sample_taken <= sample_valid && !sample_stall;
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %h", $time, result);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("phi_new", want.phi_new, result.phi_new);
					check_field("peak_delta", want.peak_delta, result.peak_delta);
					check_field("sweep_last", want.sweep_last, result.sweep_last);
					check_field("converged", want.converged, result.converged);
				end
			end
			if (sample_valid && !sample_stall) begin
				items_accepted++;
				stencil_update(sample);
			end
		end
	end

	// sample driver
	always @(negedge clk) begin
		if (sample_valid && !sample_taken) begin
			// transfer pending, hold payload
		end else if (send_gap > 0) begin
			sample_valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (!calm && pending_samples.size() != 0 && $urandom_range(0, 5) == 0) begin
			sample_valid <= 1'b0;
			send_gap <= $urandom_range(0, 7);
		end else if (pending_samples.size() != 0) begin
			sample <= pending_samples.pop_front();
			sample_valid <= 1'b1;
		end else begin
			sample_valid <= 1'b0;
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (long_hold_go && !long_hold_done) begin
			result_stall <= 1'b1;
			hold_left <= LONG_HOLD;
			long_hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			result_stall <= 1'b1;
			hold_left <= $urandom_range(0, 7);
		end else begin
			result_stall <= 1'b0;
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			jps_pkg::REG_GRID_SIZE:    cfg_grid = value[10:0];
			jps_pkg::REG_STEP_SQUARED: cfg_h2 = value;
			jps_pkg::REG_TOLERANCE:    cfg_tol = value[30:0];
			default: ;
		endcase
	endtask

	task automatic push_point(input logic [31:0] phi, input logic [31:0] src);
		jps_pkg::sample_t s;
		s.phi_old = phi;
		s.source = src;
		pending_samples.push_back(s);
		items_pushed++;
	endtask

	// block idle: everything sent, every result in, pipeline flushed
	task automatic settle();
		while (items_accepted != items_pushed || expected_results.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// 3x3 padded grid: boundary phi b, center phi and source given
	task automatic push_unit_grid(input logic [31:0] b, input logic [31:0] cp,
			input logic [31:0] cs);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				if (r == 1 && c == 1) push_point(cp, cs);
				else push_point(b, $urandom());
	endtask

	function automatic logic [31:0] rand_value(input bit smooth);
		if (smooth) return 32'(int'($urandom_range(0, 128)) - 64);
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3: return '1;
			4, 5: return 32'(int'($urandom_range(0, 8192)) - 4096);
			default: return $urandom();
		endcase
	endfunction

	initial begin : stimulus
		int unsigned n_cfg;
		int unsigned n_eff;
		int unsigned count;
		int unsigned random_sent;
		bit smooth;
		logic [31:0] h2_val;
		logic [30:0] tol_val;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// writes land during the line buffer clearing pass
		reg_write(jps_pkg::REG_GRID_SIZE, 32'd1);
		reg_write(jps_pkg::REG_STEP_SQUARED, 32'hFFFF_FFFF);
		reg_write(jps_pkg::REG_TOLERANCE, 32'd0);
		// positive saturation, difference saturates
		push_unit_grid(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
		settle();
		// grid size zero acts as one; negative saturation, then a flat converged sweep
		reg_write(jps_pkg::REG_GRID_SIZE, 32'd0);
		reg_write(jps_pkg::REG_TOLERANCE, 32'hFFFF_FFFF);
		push_unit_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push_unit_grid(32'h0, 32'h0, 32'h0);
		settle();

		// walk to row 2 on a small grid, then a full row at the largest size
		reg_write(jps_pkg::REG_GRID_SIZE, 32'd3);
		for (int i = 0; i < 10; i++) push_point(rand_value(0), rand_value(0));
		settle();
		reg_write(jps_pkg::REG_GRID_SIZE, MAX_GRID);
		reg_write(jps_pkg::REG_STEP_SQUARED, $urandom());
		for (int i = 0; i < MAX_GRID + 2; i++) push_point(rand_value(0), rand_value(0));
		long_hold_go = 1'b1;
		settle();
		// out of range size clamps to MAX_GRID
		reg_write(jps_pkg::REG_GRID_SIZE, 32'h7FF);
		for (int i = 0; i < 30; i++) push_point(rand_value(0), rand_value(0));
		settle();

		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if (random_sent + 250 >= RANDOM_ITEMS) calm = 1'b1;
			case ($urandom_range(0, 11))
				0: n_cfg = 0;
				1: n_cfg = 1;
				default: n_cfg = $urandom_range(1, 8);
			endcase
			case ($urandom_range(0, 5))
				0: h2_val = '0;
				1: h2_val = '1;
				2: h2_val = jps_pkg::STEP_SQUARED_RST;
				default: h2_val = $urandom();
			endcase
			case ($urandom_range(0, 4))
				0: tol_val = '0;
				1: tol_val = '1;
				2, 3: tol_val = 31'($urandom_range(0, 400));
				default: tol_val = 31'($urandom());
			endcase
			// upper bits of the size word are don't-care
			reg_write(jps_pkg::REG_GRID_SIZE, ($urandom() & ~32'h7FF) | n_cfg);
			reg_write(jps_pkg::REG_STEP_SQUARED, h2_val);
			reg_write(jps_pkg::REG_TOLERANCE, {1'($urandom()), tol_val});
			n_eff = (n_cfg == 0) ? 1 : n_cfg;
			smooth = ($urandom_range(0, 2) == 0);
			count = $urandom_range(1, 3) * (n_eff + 2) * (n_eff + 2);
			// sometimes stop partway so the next size change lands mid-sweep
			if ($urandom_range(0, 3) == 0) count += $urandom_range(1, 3 * n_eff + 3);
			for (int i = 0; i < count; i++) push_point(rand_value(smooth), rand_value(smooth));
			random_sent += count;
			settle();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
